[rtl/soa_pkg.sv]
// ----------------------------------------------------------------------------
// soa_pkg
// Shared constants, types and helper functions for the slab object allocator.
// ----------------------------------------------------------------------------
package soa_pkg;

	localparam int NUM_PAGES      = 64;
	localparam int PAGE_BYTES     = 4096;
	localparam int DATA_BYTES     = 3968;
	localparam int NUM_CLASSES    = 200;
	localparam int MIN_OBJ        = 8;
	localparam int ALIGN_BYTES    = 4;

	localparam int MAX_SIZE       = (NUM_CLASSES - 1 + MIN_OBJ / ALIGN_BYTES) * ALIGN_BYTES;
	localparam int SLOTS_MAX      = DATA_BYTES / MIN_OBJ;
	localparam int WORDS_PER_PAGE = (SLOTS_MAX + 63) / 64;

	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int PG_W       = $clog2(NUM_PAGES);
	localparam int PCNT_W     = $clog2(NUM_PAGES + 1);
	localparam int WIDX_W     = $clog2(WORDS_PER_PAGE);
	localparam int SLOT_W     = WIDX_W + 6;
	localparam int CLS_W      = 8;
	localparam int RND_W      = $clog2(MAX_SIZE + ALIGN_BYTES);
	localparam int DIV_W      = $clog2(DATA_BYTES + 1);

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_SIZE  = 2'd1,
		ST_EXHAUSTED = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic [CLS_W-1:0]  cls;
		logic [SLOT_W-1:0] used;
		logic [SLOT_W-1:0] guess;
	} meta_t;

	// slots of word widx that lie in [lo, n)
	function automatic logic [63:0] elig_mask(input logic [WIDX_W-1:0] widx,
		input logic [SLOT_W-1:0] lo, input logic [SLOT_W-1:0] n);
		logic [63:0]       m;
		logic [SLOT_W-1:0] idx;
		m = '0;
		for (int i = 0; i < 64; i++) begin
			idx  = {widx, 6'(i)};
			m[i] = (idx >= lo) && (idx < n);
		end
		return m;
	endfunction

	// lowest set bit
	function automatic logic [5:0] first_one(input logic [63:0] v);
		logic [5:0] p;
		p = '0;
		for (int i = 63; i >= 0; i--) begin
			if (v[i]) begin
				p = 6'(i);
			end
		end
		return p;
	endfunction

endpackage

[rtl/soa_req_if.sv]
// ----------------------------------------------------------------------------
// soa_req_if
// Request channel: alloc or free item.
// ----------------------------------------------------------------------------
interface soa_req_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [15:0] object_size;
	logic [31:0] object_address;

	modport source (output valid, mode, object_size, object_address, input ready);
	modport sink (input valid, mode, object_size, object_address, output ready);
endinterface

[rtl/soa_rsp_if.sv]
// ----------------------------------------------------------------------------
// soa_rsp_if
// Response channel: granted address and status.
// ----------------------------------------------------------------------------
interface soa_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] granted_address;
	logic [1:0]  status;

	modport source (output valid, granted_address, status, input ready);
	modport sink (input valid, granted_address, status, output ready);
endinterface

[rtl/soa_cfg_if.sv]
// ----------------------------------------------------------------------------
// soa_cfg_if
// Configuration write channel for the pool base register.
// ----------------------------------------------------------------------------
interface soa_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] pool_base;

	modport source (output valid, pool_base, input ready);
	modport sink (input valid, pool_base, output ready);
endinterface

[rtl/soa_div.sv]
// ----------------------------------------------------------------------------
// soa_div
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module soa_div import soa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [RND_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [RND_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [RND_W-1:0] div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [RND_W:0]   shifted;
	logic             ge;

	assign shifted  = {rem_q, quo_q[DIV_W-1]};
	assign ge       = shifted >= {1'b0, div_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? RND_W'(shifted - {1'b0, div_q}) : shifted[RND_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

endmodule

[rtl/slab_object_allocator.sv]
// ----------------------------------------------------------------------------
// slab_object_allocator
// Slab allocator with per-page occupancy bitmaps and a bump page pool.
// ----------------------------------------------------------------------------
// One item is handled at a time; req.ready is high only while idle. Every
// item with a legal size first waits on the shared divider to get the slots
// per page. An alloc then visits pages newest first, whatever their class,
// reading each page's metadata, scans the bitmap words of a matching page
// that has room, then forms and posts the address; a new page first has its
// whole bitmap cleared. A free visits pages likewise, waits on the divider a
// second time for the slot index, then reads and updates the bitmap word and
// posts. A bad size goes straight to the done state. The result sits in an
// output register, so while a response is stalled one more item can be
// accepted and finished; it then waits in the done state and the request side
// stalls. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module slab_object_allocator import soa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	soa_req_if.sink     req,
	soa_rsp_if.source   rsp,
	soa_cfg_if.sink     cfg
);

	typedef enum logic [3:0] {
		S_IDLE, S_DIV_N, S_NEXT, S_META_RD, S_META_CHK, S_WORD_RD, S_WORD_CHK,
		S_TAKE_CLR, S_GRANT, S_DIV_S, S_FREE_RD, S_FREE_CHK, S_DONE
	} state_t;

	state_t            state_q;
	logic [31:0]       pool_base_q;
	logic [PCNT_W-1:0] pages_taken_q;
	logic [PCNT_W-1:0] k_q;
	logic [PG_W-1:0]   pg_q;
	logic [WIDX_W-1:0] widx_q;
	logic              phase1_q;
	logic              mode_q;
	logic [31:0]       addr_q;
	logic [31:0]       rel_q;
	logic [RND_W-1:0]  rounded_q;
	logic [CLS_W-1:0]  cls_q;
	logic [SLOT_W-1:0] nslots_q;
	logic [SLOT_W-1:0] guess_q;
	logic [SLOT_W-1:0] used_q;
	logic [SLOT_W-1:0] slot_q;
	logic [31:0]       fin_addr_q;
	status_t           fin_status_q;
	logic              rsp_valid_q;
	logic [31:0]       rsp_addr_q;
	status_t           rsp_status_q;

	// memories
	meta_t             meta_mem [NUM_PAGES];
	logic [63:0]       bm_mem [NUM_PAGES*WORDS_PER_PAGE];
	meta_t             meta_rdata_q;
	logic [63:0]       bm_rdata_q;
	logic              meta_we_q;
	logic [PG_W-1:0]   meta_waddr_q;
	meta_t             meta_wdata_q;
	logic              bm_we_q;
	logic [PG_W+WIDX_W-1:0] bm_waddr_q;
	logic [63:0]       bm_wdata_q;

	// divider
	logic              div_start_q;
	logic [DIV_W-1:0]  div_a_q;
	logic              div_done;
	logic [DIV_W-1:0]  div_quo;

	logic              bad_size;
	logic [RND_W-1:0]  rnd_in;
	logic [63:0]       free_bits;
	logic [5:0]        free_pos;
	logic [SLOT_W-1:0] last_slot;
	logic [31:0]       page_off;
	logic [31:0]       off;
	logic [SLOT_W+RND_W-1:0] prod;
	logic              take_out;

	soa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_a_q),
		.divisor  (rounded_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.granted_address = rsp_addr_q;
	assign rsp.status = rsp_status_q;

	assign bad_size  = (req.object_size < 16'(MIN_OBJ)) || (req.object_size > 16'(MAX_SIZE));
	assign rnd_in    = (req.object_size[RND_W-1:0] + RND_W'(ALIGN_BYTES - 1))
		& ~RND_W'(ALIGN_BYTES - 1);
	assign free_bits = elig_mask(widx_q, phase1_q ? guess_q : '0, nslots_q) & ~bm_rdata_q;
	assign free_pos  = first_one(free_bits);
	assign last_slot = nslots_q - 1'b1;
	assign page_off  = 32'(pg_q) << PAGE_SHIFT;
	assign off       = rel_q - page_off;
	assign prod      = {{RND_W{1'b0}}, slot_q} * {{SLOT_W{1'b0}}, rounded_q};
	assign take_out  = rsp_valid_q && rsp.ready;

	always_ff @(posedge clk) begin
		meta_rdata_q <= meta_mem[pg_q];
		bm_rdata_q   <= bm_mem[{pg_q, widx_q}];
		if (meta_we_q) begin
			meta_mem[meta_waddr_q] <= meta_wdata_q;
		end
		if (bm_we_q) begin
			bm_mem[bm_waddr_q] <= bm_wdata_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			pool_base_q   <= '0;
			pages_taken_q <= '0;
			rsp_valid_q   <= 1'b0;
			meta_we_q     <= 1'b0;
			bm_we_q       <= 1'b0;
			div_start_q   <= 1'b0;
		end else begin
			meta_we_q   <= 1'b0;
			bm_we_q     <= 1'b0;
			div_start_q <= 1'b0;
			if (take_out) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg.valid) begin
				pool_base_q <= cfg.pool_base;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						mode_q    <= req.mode;
						addr_q    <= req.object_address;
						rounded_q <= rnd_in;
						cls_q     <= CLS_W'(rnd_in / RND_W'(ALIGN_BYTES))
							- CLS_W'(MIN_OBJ / ALIGN_BYTES);
						div_a_q   <= DIV_W'(DATA_BYTES);
						if (bad_size) begin
							fin_addr_q   <= '0;
							fin_status_q <= ST_BAD_SIZE;
							state_q      <= S_DONE;
						end else begin
							div_start_q <= 1'b1;
							state_q     <= S_DIV_N;
						end
					end
				end
				S_DIV_N: begin
					if (div_done) begin
						nslots_q <= SLOT_W'(div_quo);
						k_q      <= pages_taken_q;
						rel_q    <= addr_q - pool_base_q;
						if (!mode_q && div_quo == '0) begin
							fin_addr_q   <= '0;
							fin_status_q <= ST_EXHAUSTED;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_NEXT;
						end
					end
				end
				S_NEXT: begin
					if (k_q == '0) begin
						fin_addr_q <= '0;
						if (mode_q) begin
							fin_status_q <= ST_NOT_FOUND;
							state_q      <= S_DONE;
						end else if (pages_taken_q == PCNT_W'(NUM_PAGES)) begin
							fin_status_q <= ST_EXHAUSTED;
							state_q      <= S_DONE;
						end else begin
							pg_q    <= pages_taken_q[PG_W-1:0];
							widx_q  <= '0;
							state_q <= S_TAKE_CLR;
						end
					end else begin
						pg_q    <= PG_W'(k_q - 1'b1);
						k_q     <= k_q - 1'b1;
						state_q <= S_META_RD;
					end
				end
				S_META_RD: begin
					state_q <= S_META_CHK;
				end
				S_META_CHK: begin
					used_q  <= meta_rdata_q.used;
					guess_q <= meta_rdata_q.guess;
					state_q <= S_NEXT;
					if (meta_rdata_q.cls == cls_q) begin
						if (!mode_q && meta_rdata_q.used < nslots_q) begin
							if (meta_rdata_q.guess < nslots_q) begin
								widx_q   <= meta_rdata_q.guess[SLOT_W-1:6];
								phase1_q <= 1'b1;
							end else begin
								widx_q   <= '0;
								phase1_q <= 1'b0;
							end
							state_q <= S_WORD_RD;
						end else if (mode_q && meta_rdata_q.used != '0
							&& off < 32'(DATA_BYTES)) begin
							div_a_q     <= off[DIV_W-1:0];
							div_start_q <= 1'b1;
							state_q     <= S_DIV_S;
						end
					end
				end
				S_WORD_RD: begin
					state_q <= S_WORD_CHK;
				end
				S_WORD_CHK: begin
					if (free_bits != '0) begin
						slot_q       <= {widx_q, free_pos};
						bm_we_q      <= 1'b1;
						bm_waddr_q   <= {pg_q, widx_q};
						bm_wdata_q   <= bm_rdata_q | (64'd1 << free_pos);
						meta_we_q    <= 1'b1;
						meta_waddr_q <= pg_q;
						meta_wdata_q <= '{cls: cls_q, used: used_q + 1'b1,
							guess: {widx_q, free_pos} + 1'b1};
						state_q      <= S_GRANT;
					end else if (widx_q == last_slot[SLOT_W-1:6]) begin
						// wrap to slot zero once, a page with room always has a hit
						widx_q   <= '0;
						phase1_q <= 1'b0;
						state_q  <= phase1_q ? S_WORD_RD : S_NEXT;
					end else begin
						widx_q  <= widx_q + 1'b1;
						state_q <= S_WORD_RD;
					end
				end
				S_TAKE_CLR: begin
					// fresh page: clear every word, slot zero goes out at once
					bm_we_q    <= 1'b1;
					bm_waddr_q <= {pg_q, widx_q};
					bm_wdata_q <= (widx_q == '0) ? 64'd1 : 64'd0;
					widx_q     <= widx_q + 1'b1;
					if (widx_q == WIDX_W'(WORDS_PER_PAGE - 1)) begin
						meta_we_q     <= 1'b1;
						meta_waddr_q  <= pg_q;
						meta_wdata_q  <= '{cls: cls_q, used: SLOT_W'(1), guess: SLOT_W'(1)};
						pages_taken_q <= pages_taken_q + 1'b1;
						slot_q        <= '0;
						state_q       <= S_GRANT;
					end
				end
				S_GRANT: begin
					fin_addr_q   <= pool_base_q + page_off + 32'(prod);
					fin_status_q <= ST_OK;
					state_q      <= S_DONE;
				end
				S_DIV_S: begin
					if (div_done) begin
						if (div_quo >= DIV_W'(nslots_q)) begin
							fin_addr_q   <= '0;
							fin_status_q <= ST_NOT_FOUND;
							state_q      <= S_DONE;
						end else begin
							slot_q  <= SLOT_W'(div_quo);
							widx_q  <= div_quo[SLOT_W-1:6];
							state_q <= S_FREE_RD;
						end
					end
				end
				S_FREE_RD: begin
					state_q <= S_FREE_CHK;
				end
				S_FREE_CHK: begin
					fin_addr_q <= '0;
					if (!bm_rdata_q[slot_q[5:0]]) begin
						fin_status_q <= ST_NOT_FOUND;
					end else begin
						bm_we_q      <= 1'b1;
						bm_waddr_q   <= {pg_q, widx_q};
						bm_wdata_q   <= bm_rdata_q & ~(64'd1 << slot_q[5:0]);
						meta_we_q    <= 1'b1;
						meta_waddr_q <= pg_q;
						meta_wdata_q <= '{cls: cls_q, used: used_q - 1'b1, guess: slot_q};
						fin_status_q <= ST_OK;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_addr_q   <= fin_addr_q;
						rsp_status_q <= fin_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_pages_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pages_taken_q <= PCNT_W'(NUM_PAGES))
		else $error("pages_taken beyond pool");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_status_q != ST_OK |-> rsp_addr_q == '0)
		else $error("failed item carries an address");

	a_div_expected: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV_N || state_q == S_DIV_S))
		else $error("divider result with nobody waiting");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken twice in a row");
`endif

endmodule

[sim/tb_slab_object_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_slab_object_allocator
// Drives alloc and free requests into the slab allocator and compares each
// response with a cycle-free prediction of page, class and bitmap state.
// Covers size limits, double frees, tail slack, interior addresses, address
// wrap, pool exhaustion and several idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module tb_slab_object_allocator;
	import soa_pkg::*;

	localparam int LIMIT_CYCLES = 4000000;

	typedef struct {
		logic [31:0] addr;
		status_t     st;
	} reply_t;

	typedef struct {
		int pg;
		int slot;
		int rnd;
	} obj_t;

	logic clk;
	logic arst_n;

	soa_req_if req ();
	soa_rsp_if rsp ();
	soa_cfg_if cfg ();

	slab_object_allocator i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	// predicted allocator state
	logic [31:0] pool_base_m;
	int          pages_m;
	int          cls_m   [NUM_PAGES];
	int          used_m  [NUM_PAGES];
	int          guess_m [NUM_PAGES];
	bit          busy_m  [NUM_PAGES][SLOTS_MAX];

	reply_t      replies_q[$];
	obj_t        live_q[$];
	int          errors;
	int          send_idle_pct;
	int          rsp_stall_pct;
	int          hold_cycles;
	longint      cycles = 0;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// response ready, with an optional long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			rsp.ready <= 1'b0;
			hold_cycles = hold_cycles - 1;
		end else begin
			rsp.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
		end
	end

	always @(posedge clk) begin
		reply_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (replies_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result addr=%h status=%0d",
						rsp.granted_address, rsp.status);
			end else begin
				e = replies_q.pop_front();
				if (rsp.granted_address !== e.addr || rsp.status !== e.st) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected addr=%h status=%0d, got addr=%h status=%0d",
							e.addr, e.st, rsp.granted_address, rsp.status);
				end
			end
		end
	end

	function automatic logic [31:0] page_base(int pg);
		return pool_base_m + 32'(pg) * 32'(PAGE_BYTES);
	endfunction

	function automatic logic [31:0] obj_addr(obj_t o);
		return page_base(o.pg) + 32'(o.slot) * 32'(o.rnd);
	endfunction

	// computes the reply and updates the state; pg/slot tell what changed
	function automatic reply_t allocate_or_free(bit m, logic [15:0] sz, logic [31:0] a,
		output int pg_o, output int slot_o);
		reply_t      r;
		int          rnd, cls, nslots, pg, s, j;
		logic [31:0] off;
		bit          hit;
		r.addr = '0;
		r.st   = ST_OK;
		pg_o   = -1;
		slot_o = -1;
		hit    = 0;
		pg     = -1;
		s      = 0;
		if (sz < MIN_OBJ || sz > MAX_SIZE) begin
			r.st = ST_BAD_SIZE;
			return r;
		end
		rnd    = (int'(sz) + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
		cls    = rnd / ALIGN_BYTES - MIN_OBJ / ALIGN_BYTES;
		nslots = DATA_BYTES / rnd;
		if (nslots > SLOTS_MAX) nslots = SLOTS_MAX;
		if (m == 1'b0) begin
			if (nslots == 0) begin
				r.st = ST_EXHAUSTED;
				return r;
			end
			for (int k = pages_m; k > 0 && !hit; k--) begin
				if (cls_m[k-1] == cls && used_m[k-1] < nslots) begin
					for (j = 0; j < nslots && !hit; j++) begin
						if (!busy_m[k-1][(guess_m[k-1] + j) % nslots]) begin
							hit = 1;
							pg  = k - 1;
							s   = (guess_m[k-1] + j) % nslots;
						end
					end
				end
			end
			if (!hit) begin
				if (pages_m >= NUM_PAGES) begin
					r.st = ST_EXHAUSTED;
					return r;
				end
				pg = pages_m;
				pages_m++;
				cls_m[pg]   = cls;
				used_m[pg]  = 0;
				guess_m[pg] = 0;
				for (int i = 0; i < SLOTS_MAX; i++) busy_m[pg][i] = 0;
				s = 0;
			end
			busy_m[pg][s] = 1;
			guess_m[pg]   = s + 1;
			used_m[pg]++;
			r.addr = page_base(pg) + 32'(s) * 32'(rnd);
			pg_o   = pg;
			slot_o = s;
			return r;
		end
		for (int k = pages_m; k > 0; k--) begin
			if (cls_m[k-1] == cls && used_m[k-1] != 0) begin
				off = a - page_base(k - 1);
				if (off < DATA_BYTES) begin
					s = int'(off) / rnd;
					if (s >= nslots || !busy_m[k-1][s]) break;
					busy_m[k-1][s] = 0;
					used_m[k-1]--;
					guess_m[k-1] = s;
					pg_o   = k - 1;
					slot_o = s;
					return r;
				end
			end
		end
		r.st = ST_NOT_FOUND;
		return r;
	endfunction

	task automatic send_item(bit m, logic [15:0] sz, logic [31:0] a);
		reply_t r;
		obj_t   o;
		int     pg, slot;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req.valid = 1'b0;
			@(negedge clk);
		end
		req.valid          = 1'b1;
		req.mode           = m;
		req.object_size    = sz;
		req.object_address = a;
		do @(posedge clk); while (!req.ready);
		r = allocate_or_free(m, sz, a, pg, slot);
		replies_q.push_back(r);
		if (pg >= 0) begin
			if (m == 1'b0) begin
				o.pg   = pg;
				o.slot = slot;
				o.rnd  = (int'(sz) + 3) / 4 * 4;
				live_q.push_back(o);
			end else begin
				foreach (live_q[i])
					if (live_q[i].pg == pg && live_q[i].slot == slot) begin
						live_q.delete(i);
						break;
					end
			end
		end
	endtask

	task automatic idle_sender();
		@(negedge clk);
		req.valid = 1'b0;
	endtask

	task automatic wait_drained();
		idle_sender();
		while (replies_q.size() != 0) @(negedge clk);
	endtask

	task automatic write_pool_base(logic [31:0] v);
		wait_drained();
		repeat (40) @(negedge clk);
		cfg.valid     = 1'b1;
		cfg.pool_base = v;
		do @(posedge clk); while (!cfg.ready);
		pool_base_m = v;
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	task automatic test_directed();
		logic [31:0] b;
		write_pool_base(32'h0000_0000);
		send_item(1'b0, 16'd8, 32'hFFFF_FFFF);       // class 0, new page
		send_item(1'b0, 16'd9, 32'h0);               // rounds to 12
		send_item(1'b0, 16'd804, 32'h0);             // largest class
		send_item(1'b0, 16'd7, 32'h0);               // below minimum
		send_item(1'b0, 16'd805, 32'h0);             // above maximum
		send_item(1'b0, 16'd0, 32'h0);
		send_item(1'b0, 16'hFFFF, 32'hFFFF_FFFF);
		send_item(1'b1, 16'd3, 32'h0);               // free with bad size
		send_item(1'b0, 16'd8, 32'h0);
		send_item(1'b1, 16'd8, 32'h0000_0004);       // interior address
		send_item(1'b1, 16'd8, 32'h0000_0000);       // double free
		send_item(1'b0, 16'd8, 32'h0);               // reuses the freed slot
		b = page_base(2);
		send_item(1'b1, 16'd804, b + 32'd3300);      // tail slack
		send_item(1'b1, 16'd804, b + 32'd4000);      // past data area
		send_item(1'b1, 16'd12, b);                  // wrong class
		send_item(1'b1, 16'd801, b + 32'd803);       // same class, interior
		send_item(1'b1, 16'd100, 32'h1234_5678);     // class with no pages
		wait_drained();
		write_pool_base(32'hFFFF_F000);              // page 1 onward wraps
		send_item(1'b0, 16'd10, 32'h0);
		send_item(1'b0, 16'd12, 32'h0);
		send_item(1'b1, 16'd12, 32'h0000_0000);
		send_item(1'b1, 16'd8, 32'hFFFF_F008);
		wait_drained();
	endtask

	task automatic random_phase(int n_items, int idle_pct, int stall_pct);
		logic [15:0] sizes[3];
		obj_t        o;
		int          idx, rnd;
		send_idle_pct = idle_pct;
		rsp_stall_pct = stall_pct;
		sizes[0] = 16'($urandom_range(8, 64));
		sizes[1] = 16'($urandom_range(8, 200));
		sizes[2] = 16'($urandom_range(8, MAX_SIZE));
		repeat (n_items) begin
			if ($urandom_range(0, 99) < 10) begin
				if ($urandom_range(0, 1))
					send_item(1'($urandom), ($urandom_range(0, 1) ?
						16'($urandom_range(0, MIN_OBJ - 1)) :
						16'($urandom_range(MAX_SIZE + 1, 65535))), $urandom);
				else
					send_item(1'b1, sizes[$urandom_range(0, 2)], $urandom);
			end else if (live_q.size() != 0 &&
					(live_q.size() > 40 || $urandom_range(0, 99) < 40)) begin
				idx = $urandom_range(0, live_q.size() - 1);
				o   = live_q[idx];
				rnd = o.rnd;
				send_item(1'b1, 16'(rnd - (rnd == 8 ? 0 : $urandom_range(0, 3))),
					obj_addr(o) + ($urandom_range(0, 3) == 0 ?
						32'($urandom_range(0, rnd - 1)) : 32'd0));
			end else begin
				send_item(1'b0, sizes[$urandom_range(0, 2)], $urandom);
			end
		end
		wait_drained();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		hold_cycles   = 400;
		repeat (20) send_item(1'b0, 16'd16, 32'h0);
		wait_drained();
		repeat (10) send_item(1'b1, 16'd16, live_q[live_q.size() - 1].pg * 0 +
			obj_addr(live_q[live_q.size() - 1]));
		wait_drained();
	endtask

	task automatic test_exhaustion();
		obj_t o;
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		while (pages_m < NUM_PAGES) send_item(1'b0, 16'd804, 32'h0);
		send_item(1'b0, 16'd804, 32'h0);
		send_item(1'b0, 16'd804, 32'h0);
		send_item(1'b0, 16'd8, 32'h0);
		send_item(1'b0, 16'd500, 32'h0);              // class with no page
		o = live_q[live_q.size() - 1];
		send_item(1'b1, 16'd804, obj_addr(o));
		send_item(1'b0, 16'd804, 32'h0);
		wait_drained();
	endtask

	initial begin
		arst_n             = 1'b0;
		req.valid          = 1'b0;
		req.mode           = 1'b0;
		req.object_size    = '0;
		req.object_address = '0;
		cfg.valid          = 1'b0;
		cfg.pool_base      = '0;
		errors             = 0;
		hold_cycles        = 0;
		send_idle_pct      = 0;
		rsp_stall_pct      = 0;
		pool_base_m        = '0;
		pages_m            = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		write_pool_base(32'h0000_0000);
		random_phase(110, 0, 0);
		write_pool_base({20'($urandom_range(0, 32'hFFFFF)), 12'h000});
		random_phase(110, 65, 0);
		write_pool_base(32'hFFFF_FFFF);
		random_phase(110, 0, 65);
		write_pool_base($urandom);
		random_phase(110, 19, 19);
		test_backpressure();
		test_exhaustion();

		wait_drained();
		repeat (200) @(posedge clk);
		if (errors == 0 && replies_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/soa_pkg.sv
rtl/soa_req_if.sv
rtl/soa_rsp_if.sv
rtl/soa_cfg_if.sv
rtl/soa_div.sv
rtl/slab_object_allocator.sv
sim/tb_slab_object_allocator.sv
